>>> rtl/sfvp_pkg.sv
// Shared types and constants of the sync frame validating parser.
`timescale 1ns / 1ps

package sfvp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned FIELD_W      = 32;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned PHASE_W      = 5;
  localparam int unsigned CFG_INDEX_W  = 3;
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;

  // Byte positions within a frame.
  localparam logic [PHASE_W-1:0] PH_TYPE      = 5'd0;
  localparam logic [PHASE_W-1:0] PH_VERSION   = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ID1_END   = 5'd5;
  localparam logic [PHASE_W-1:0] PH_ID2_END   = 5'd9;
  localparam logic [PHASE_W-1:0] PH_ID3_END   = 5'd13;
  localparam logic [PHASE_W-1:0] PH_ACK_LIMIT = 5'd14;
  localparam logic [PHASE_W-1:0] PH_FIELD_END = 5'd17;
  localparam logic [PHASE_W-1:0] PH_ACCESS    = 5'd18;
  localparam logic [PHASE_W-1:0] PH_ACCEPTED  = 5'd19;
  localparam logic [PHASE_W-1:0] PHASE_MAX    = 5'd20;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNKNOWN    = 3'd0,
    KIND_NODE_STATE = 3'd1,
    KIND_ACK        = 3'd2,
    KIND_OFFER      = 3'd3,
    KIND_REQUEST    = 3'd4,
    KIND_DECISION   = 3'd5
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PROTOCOL_VERSION    = 3'd0,
    CFG_CODE_NODE_STATE     = 3'd1,
    CFG_CODE_ACK            = 3'd2,
    CFG_CODE_SHARE_OFFER    = 3'd3,
    CFG_CODE_SHARE_DECISION = 3'd4,
    CFG_CODE_SHARE_REQUEST  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic               payload_strobe;
    logic [BYTE_W-1:0]  payload_byte;
    logic               frame_done;
    logic               frame_ok;
    logic [KIND_W-1:0]  frame_kind;
    logic [FIELD_W-1:0] first_id;
    logic [FIELD_W-1:0] second_id;
    logic [FIELD_W-1:0] third_id;
    logic [FIELD_W-1:0] root_class;
    logic               access_mode;
    logic               accepted_flag;
    logic [FIELD_W-1:0] payload_length;
  } out_item_t;

endpackage

>>> rtl/sync_frame_validating_parser_unit.sv
// Byte-serial sync frame parser: header and field checks, payload pass-through, verdict.
//
// The parser takes one frame byte per item and can accept an item in every cycle. Each byte
// updates the frame state (position, shift register, captured ids and counters) when it is
// accepted, and its result, if any, reaches the output register in the next cycle. A result
// comes only for a forwarded node state payload byte or a frame's last byte, which carries the
// verdict and all captured fields. The single output register loads whenever empty or being
// drained, so the sustained rate is one byte per cycle. The user must write type codes and the
// expected version through the configuration port only while idle; the block does not check it.
`timescale 1ns / 1ps

module sync_frame_validating_parser_unit #(
  parameter int unsigned LENGTH_BITS = sfvp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfvp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfvp_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sfvp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sfvp_pkg::BYTE_W-1:0]         cfg_data
);

  localparam int unsigned FW = sfvp_pkg::FIELD_W;
  localparam int unsigned BW = sfvp_pkg::BYTE_W;
  localparam logic [FW-1:0] LEN_LIMIT = FW'((64'd1 << LENGTH_BITS) - 64'd1);

  // Configuration registers.
  logic [BW-1:0] protocol_version;
  logic [BW-1:0] code_node_state;
  logic [BW-1:0] code_ack;
  logic [BW-1:0] code_share_offer;
  logic [BW-1:0] code_share_decision;
  logic [BW-1:0] code_share_request;

  // Frame state.
  logic [sfvp_pkg::PHASE_W-1:0] byte_phase, byte_phase_next;
  sfvp_pkg::kind_t              kind_reg, kind_next, kind_decoded;
  logic [FW-1:0]                field_shift, field_shift_next, shift_in;
  logic [FW-1:0]                id_first_reg, id_first_next;
  logic [FW-1:0]                id_second_reg, id_second_next;
  logic [FW-1:0]                id_third_reg, id_third_next;
  logic [FW-1:0]                class_reg, class_next;
  logic                         access_reg, access_next;
  logic                         accept_reg, accept_next;
  logic [FW-1:0]                length_reg, length_next;
  logic [LENGTH_BITS-1:0]       payload_left, payload_left_next;
  logic                         in_payload, in_payload_next;
  logic                         error_flag, error_next;

  logic                         strobe;
  logic                         complete;
  logic                         accept;
  logic [BW-1:0]                b;
  logic                         frame_last;
  sfvp_pkg::out_item_t          result;

  assign b          = in_data.data_byte;
  assign frame_last = in_data.frame_end;
  assign in_ready   = !out_valid || out_ready;
  assign accept     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign shift_in   = {field_shift[FW-BW-1:0], b};

  // Type match in priority order; the first matching code wins.
  always_comb begin
    if (b == code_node_state) begin
      kind_decoded = sfvp_pkg::KIND_NODE_STATE;
    end else if (b == code_ack) begin
      kind_decoded = sfvp_pkg::KIND_ACK;
    end else if (b == code_share_offer) begin
      kind_decoded = sfvp_pkg::KIND_OFFER;
    end else if (b == code_share_decision) begin
      kind_decoded = sfvp_pkg::KIND_DECISION;
    end else if (b == code_share_request) begin
      kind_decoded = sfvp_pkg::KIND_REQUEST;
    end else begin
      kind_decoded = sfvp_pkg::KIND_UNKNOWN;
    end
  end

  always_comb begin
    strobe            = 1'b0;
    kind_next         = kind_reg;
    field_shift_next  = field_shift;
    id_first_next     = id_first_reg;
    id_second_next    = id_second_reg;
    id_third_next     = id_third_reg;
    class_next        = class_reg;
    access_next       = access_reg;
    accept_next       = accept_reg;
    length_next       = length_reg;
    payload_left_next = payload_left;
    in_payload_next   = in_payload;
    error_next        = error_flag;

    if (byte_phase == sfvp_pkg::PH_TYPE) begin
      kind_next = kind_decoded;
      if (kind_decoded == sfvp_pkg::KIND_UNKNOWN) error_next = 1'b1;
    end else if (byte_phase == sfvp_pkg::PH_VERSION) begin
      if (b != protocol_version) error_next = 1'b1;
    end else if (kind_reg == sfvp_pkg::KIND_UNKNOWN) begin
      // Already rejected at the type byte; nothing more is gathered.
    end else if (kind_reg == sfvp_pkg::KIND_NODE_STATE && in_payload) begin
      if (payload_left != '0) begin
        strobe            = !error_flag;
        payload_left_next = payload_left - LENGTH_BITS'(1);
      end else begin
        error_next = 1'b1;
      end
    end else if (kind_reg == sfvp_pkg::KIND_ACK && byte_phase >= sfvp_pkg::PH_ACK_LIMIT) begin
      error_next = 1'b1;
    end else if (byte_phase <= sfvp_pkg::PH_FIELD_END) begin
      field_shift_next = shift_in;
      case (byte_phase)
        sfvp_pkg::PH_ID1_END: begin
          id_first_next = shift_in;
          if (shift_in == '0) error_next = 1'b1;
        end
        sfvp_pkg::PH_ID2_END: begin
          id_second_next = shift_in;
          if (shift_in == '0) error_next = 1'b1;
        end
        sfvp_pkg::PH_ID3_END: begin
          id_third_next = shift_in;
          if (shift_in == '0) error_next = 1'b1;
        end
        sfvp_pkg::PH_FIELD_END: begin
          if (kind_reg == sfvp_pkg::KIND_NODE_STATE) begin
            length_next       = shift_in;
            payload_left_next = shift_in[LENGTH_BITS-1:0];
            in_payload_next   = 1'b1;
            if (shift_in > LEN_LIMIT) error_next = 1'b1;
          end else begin
            class_next = shift_in;
            // Share requests may carry a zero root class.
            if (shift_in == '0 && kind_reg != sfvp_pkg::KIND_REQUEST) error_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (byte_phase == sfvp_pkg::PH_ACCESS) begin
      access_next = b[0];
      if (b[BW-1:1] != '0) error_next = 1'b1;
    end else if (byte_phase == sfvp_pkg::PH_ACCEPTED && kind_reg == sfvp_pkg::KIND_DECISION) begin
      accept_next = b[0];
      if (b[BW-1:1] != '0) error_next = 1'b1;
    end else begin
      error_next = 1'b1;
    end

    if (byte_phase < sfvp_pkg::PHASE_MAX) begin
      byte_phase_next = byte_phase + 5'd1;
    end else begin
      byte_phase_next = byte_phase;
    end

    case (kind_next)
      sfvp_pkg::KIND_NODE_STATE: complete = in_payload_next && (payload_left_next == '0);
      sfvp_pkg::KIND_ACK:        complete = (byte_phase == sfvp_pkg::PH_ID3_END);
      sfvp_pkg::KIND_OFFER,
      sfvp_pkg::KIND_REQUEST:    complete = (byte_phase == sfvp_pkg::PH_ACCESS);
      sfvp_pkg::KIND_DECISION:   complete = (byte_phase == sfvp_pkg::PH_ACCEPTED);
      default:                   complete = 1'b0;
    endcase

    result                = '0;
    result.payload_strobe = strobe;
    result.payload_byte   = strobe ? b : '0;
    if (frame_last) begin
      result.frame_done     = 1'b1;
      result.frame_ok       = complete && !error_next;
      result.frame_kind     = kind_next;
      result.first_id       = id_first_next;
      result.second_id      = id_second_next;
      result.third_id       = id_third_next;
      result.root_class     = class_next;
      result.access_mode    = access_next;
      result.accepted_flag  = accept_next;
      result.payload_length = length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version    <= 8'd1;
      code_node_state     <= 8'd0;
      code_ack            <= 8'd1;
      code_share_offer    <= 8'd3;
      code_share_decision <= 8'd4;
      code_share_request  <= 8'd5;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfvp_pkg::CFG_PROTOCOL_VERSION:    protocol_version    <= cfg_data;
        sfvp_pkg::CFG_CODE_NODE_STATE:     code_node_state     <= cfg_data;
        sfvp_pkg::CFG_CODE_ACK:            code_ack            <= cfg_data;
        sfvp_pkg::CFG_CODE_SHARE_OFFER:    code_share_offer    <= cfg_data;
        sfvp_pkg::CFG_CODE_SHARE_DECISION: code_share_decision <= cfg_data;
        sfvp_pkg::CFG_CODE_SHARE_REQUEST:  code_share_request  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Frame state: the last byte of a frame starts the next one from a clean slate.
  always_ff @(posedge clk) begin
    if (rst || (accept && frame_last)) begin
      byte_phase    <= '0;
      kind_reg      <= sfvp_pkg::KIND_UNKNOWN;
      field_shift   <= '0;
      id_first_reg  <= '0;
      id_second_reg <= '0;
      id_third_reg  <= '0;
      class_reg     <= '0;
      access_reg    <= 1'b0;
      accept_reg    <= 1'b0;
      length_reg    <= '0;
      payload_left  <= '0;
      in_payload    <= 1'b0;
      error_flag    <= 1'b0;
    end else if (accept) begin
      byte_phase    <= byte_phase_next;
      kind_reg      <= kind_next;
      field_shift   <= field_shift_next;
      id_first_reg  <= id_first_next;
      id_second_reg <= id_second_next;
      id_third_reg  <= id_third_next;
      class_reg     <= class_next;
      access_reg    <= access_next;
      accept_reg    <= accept_next;
      length_reg    <= length_next;
      payload_left  <= payload_left_next;
      in_payload    <= in_payload_next;
      error_flag    <= error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && (strobe || frame_last);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= result;
    end
  end

endmodule
